[rtl/fbc_pkg.sv]
package fbc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_LD_VIEW = 2'd0,
        MODE_LD_PROJ = 2'd1,
        MODE_BUILD   = 2'd2,
        MODE_VERTEX  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  idx;
        logic [31:0] value;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        last;
    } t_item;

    // one clip plane, a*x + b*y + c*z + d
    typedef struct packed {
        logic [33:0] a;
        logic [33:0] b;
        logic [33:0] c;
        logic [33:0] d;
    } t_plane;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_DRAIN,
        S_PLANES,
        S_CORNER,
        S_CFIN,
        S_RES
    } t_state;

endpackage

[rtl/fbc_front.sv]
module fbc_front
    import fbc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [1:0]   i_mode,
    input  logic [135:0] i_data,
    input  logic         i_last,
    output logic         o_push,
    output t_item        o_item,
    input  logic         i_q_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.op    = t_op'(i_mode);
        n_item.idx   = i_data[3:0];
        n_item.value = i_data[35:4];
        n_item.vx    = i_data[67:36];
        n_item.vy    = i_data[99:68];
        n_item.vz    = i_data[131:100];
        // tlast only means something on a vertex beat
        n_item.last  = i_last && (t_op'(i_mode) == MODE_VERTEX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

[rtl/fbc_queue.sv]
module fbc_queue
    import fbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              push_ok;
    logic              pop_ok;

    assign o_ready = (r_cnt != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[rtl/fbc_back.sv]
module fbc_back
    import fbc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_item i_q_item,
    output logic  o_pop,
    output logic  o_valid,
    output logic  o_visible,
    input  logic  i_ready
);

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    t_state r_state;
    t_state n_state;

    logic [31:0] r_view [16];
    logic [31:0] r_proj [16];
    logic [31:0] r_m    [16];
    t_plane      r_plane [6];
    t_item       r_cur;
    logic [5:0]  r_hit;

    // build: product stage then accumulate stage
    logic [5:0]         r_cnt;
    logic signed [63:0] r_prod;
    logic               r_prod_vld;
    logic               r_prod_first;
    logic               r_prod_end;
    logic [3:0]         r_prod_rc;
    logic signed [65:0] r_acc;
    logic signed [65:0] acc_sum;
    logic signed [65:0] acc_sh;
    logic [31:0]        acc_q;

    // corner: product stage then sign stage
    logic [2:0]         r_pl;
    logic signed [65:0] r_mx;
    logic signed [65:0] r_my;
    logic signed [65:0] r_mz;
    logic signed [67:0] r_md;
    logic               r_pv;
    logic [2:0]         r_pp;
    logic signed [67:0] dot;
    t_plane             pl_rd;

    logic r_ov;
    logic r_vis;
    logic out_free;

    logic pop;
    logic issue_b;
    logic issue_c;
    logic res_take;

    assign out_free  = !r_ov || i_ready;
    assign o_valid   = r_ov;
    assign o_visible = r_vis;
    assign o_pop     = pop;
    assign pl_rd     = r_plane[r_pl];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.op == MODE_BUILD) begin
                        n_state = S_BUILD;
                    end else if (i_q_item.op == MODE_VERTEX) begin
                        n_state = S_CORNER;
                    end
                end
            end
            S_BUILD:  if (r_cnt == 6'd63) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_PLANES;
            S_PLANES: n_state = S_IDLE;
            S_CORNER: if (r_pl == 3'd5) n_state = S_CFIN;
            S_CFIN:   n_state = S_RES;
            S_RES:    if (!r_cur.last || out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        issue_b  = 1'b0;
        issue_c  = 1'b0;
        res_take = 1'b0;
        unique case (r_state)
            S_IDLE:   pop      = i_q_valid;
            S_BUILD:  issue_b  = 1'b1;
            S_CORNER: issue_c  = 1'b1;
            S_RES:    res_take = r_cur.last && out_free;
            default: ;
        endcase
    end

    always_comb begin
        acc_sum = (r_prod_first ? 66'sd0 : r_acc) + {{2{r_prod[63]}}, r_prod};
        acc_sh  = acc_sum >>> FRAC_BITS;
        if (acc_sh > SAT_HI) begin
            acc_q = 32'h7FFF_FFFF;
        end else if (acc_sh < SAT_LO) begin
            acc_q = 32'h8000_0000;
        end else begin
            acc_q = acc_sh[31:0];
        end
        dot = {{2{r_mx[65]}}, r_mx} + {{2{r_my[65]}}, r_my} + {{2{r_mz[65]}}, r_mz} + r_md;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_pl       <= '0;
            r_prod_vld <= 1'b0;
            r_pv       <= 1'b0;
            r_hit      <= '0;
            r_ov       <= 1'b0;
            for (int p = 0; p < 6; p++) begin
                r_plane[p] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_prod_vld <= issue_b;
            r_pv       <= issue_c;
            r_cnt      <= issue_b ? r_cnt + 1'b1 : '0;
            // plane index stays within the six planes
            r_pl       <= (issue_c && r_pl != 3'd5) ? r_pl + 1'b1 : '0;
            if (r_pv && !dot[67]) begin
                r_hit[r_pp] <= 1'b1;
            end
            if (res_take) begin
                r_hit <= '0;
            end
            if (res_take) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_PLANES) begin
                for (int r = 0; r < 4; r++) begin
                    logic signed [33:0] m0, m1, m2, m3;
                    m0 = {{2{r_m[4*r+0][31]}}, r_m[4*r+0]};
                    m1 = {{2{r_m[4*r+1][31]}}, r_m[4*r+1]};
                    m2 = {{2{r_m[4*r+2][31]}}, r_m[4*r+2]};
                    m3 = {{2{r_m[4*r+3][31]}}, r_m[4*r+3]};
                    r_plane[0][(3-r)*34 +: 34] <= m3 + m0;
                    r_plane[1][(3-r)*34 +: 34] <= m3 - m0;
                    r_plane[2][(3-r)*34 +: 34] <= m3 + m1;
                    r_plane[3][(3-r)*34 +: 34] <= m3 - m1;
                    r_plane[4][(3-r)*34 +: 34] <= m2;
                    r_plane[5][(3-r)*34 +: 34] <= m3 - m2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_q_item;
            if (i_q_item.op == MODE_LD_VIEW) begin
                r_view[i_q_item.idx] <= i_q_item.value;
            end
            if (i_q_item.op == MODE_LD_PROJ) begin
                r_proj[i_q_item.idx] <= i_q_item.value;
            end
        end
        // cnt = {row, col, k}
        r_prod       <= $signed(r_view[{r_cnt[5:4], r_cnt[1:0]}])
                      * $signed(r_proj[{r_cnt[1:0], r_cnt[3:2]}]);
        r_prod_first <= (r_cnt[1:0] == 2'd0);
        r_prod_end   <= (r_cnt[1:0] == 2'd3);
        r_prod_rc    <= r_cnt[5:2];
        if (r_prod_vld) begin
            r_acc <= acc_sum;
            if (r_prod_end) begin
                r_m[r_prod_rc] <= acc_q;
            end
        end
        r_mx <= $signed(pl_rd.a) * $signed(r_cur.vx);
        r_my <= $signed(pl_rd.b) * $signed(r_cur.vy);
        r_mz <= $signed(pl_rd.c) * $signed(r_cur.vz);
        r_md <= $signed({{34{pl_rd.d[33]}}, pl_rd.d}) <<< FRAC_BITS;
        r_pp <= r_pl;
        if (res_take) begin
            r_vis <= (r_hit == 6'h3F);
        end
    end

endmodule

[rtl/frustum_box_cull_unit.sv]
// Channel    Dir  tdata                                    tuser   tlast
// s_axis     in   element_index, element_value, x, y, z    mode    last_corner
// m_axis     out  visible                                  -       -
//
// Work: in the back end a corner runs six plane dot products through three
// shared multipliers, one plane a cycle, then the sign and result steps; a build
// runs 64 products through one multiplier.
// Reset: i_rst_n synchronous, active low; clears planes, hit bits, queue.
// Stalls: a 4-beat queue parts the input side from the back end; the result
// register lets the back end go on with loads and corners while it waits.
module frustum_box_cull_unit
    import fbc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // element_index[3:0], element_value[35:4], vertex_x[67:36],
    // vertex_y[99:68], vertex_z[131:100], zero pad
    input  logic [135:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // visible[0], zero pad
    output logic [7:0]   m_axis_tdata
);

    logic  push;
    logic  q_ready;
    logic  q_valid;
    logic  pop;
    logic  visible;
    t_item f_item;
    t_item q_item;

    fbc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_mode    (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .o_push    (push),
        .o_item    (f_item),
        .i_q_ready (q_ready)
    );

    fbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    fbc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .o_visible (visible),
        .i_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, visible};

endmodule

[tb/tb_frustum_box_cull_unit.sv]
`timescale 1ns / 1ps

module tb_frustum_box_cull_unit;
    import fbc_pkg::*;

    localparam int FRAC = 16;

    typedef struct {
        t_op         op;
        logic [3:0]  idx;
        logic [31:0] value;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        last;
    } t_beat;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;

    frustum_box_cull_unit #(.FRAC_BITS(FRAC)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    logic signed [31:0] view_m [16];
    logic signed [31:0] proj_m [16];
    logic signed [33:0] planes [24];
    logic [5:0]         hit_bits;

    t_beat   pending_beats[$];
    bit      visible_q[$];
    int      mismatches;
    bit      hold_sender;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [31:0] mat_entry(int r, int c);
        logic signed [95:0] acc;
        logic signed [95:0] sh;
        acc = '0;
        for (int k = 0; k < 4; k++)
            acc += 96'(view_m[4*r+k]) * 96'(proj_m[4*k+c]);
        sh = acc >>> FRAC;
        if (sh > 96'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (sh < -96'sh8000_0000) return 32'sh8000_0000;
        return sh[31:0];
    endfunction

    task automatic build_planes();
        logic signed [33:0] m [4][4];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = 34'(mat_entry(r, c));
        for (int r = 0; r < 4; r++) begin
            planes[0*4+r] = m[r][3] + m[r][0];
            planes[1*4+r] = m[r][3] - m[r][0];
            planes[2*4+r] = m[r][3] + m[r][1];
            planes[3*4+r] = m[r][3] - m[r][1];
            planes[4*4+r] = m[r][2];
            planes[5*4+r] = m[r][3] - m[r][2];
        end
    endtask

    // runs one accepted beat through the predictor
    task automatic predict_beat(t_beat b);
        logic signed [95:0] dot;
        case (b.op)
            MODE_LD_VIEW: view_m[b.idx] = b.value;
            MODE_LD_PROJ: proj_m[b.idx] = b.value;
            MODE_BUILD:   build_planes();
            default: begin
                for (int p = 0; p < 6; p++) begin
                    dot = 96'(planes[4*p]) * 96'($signed(b.vx))
                        + 96'(planes[4*p+1]) * 96'($signed(b.vy))
                        + 96'(planes[4*p+2]) * 96'($signed(b.vz))
                        + (96'(planes[4*p+3]) <<< FRAC);
                    if (dot >= 0) hit_bits[p] = 1'b1;
                end
                if (b.last) begin
                    visible_q.push_back(hit_bits == 6'h3F);
                    hit_bits = '0;
                end
            end
        endcase
    endtask

    function automatic t_beat mk(t_op op, logic [3:0] idx, logic [31:0] v,
                                 logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic last);
        t_beat b;
        b.op = op; b.idx = idx; b.value = v;
        b.vx = x; b.vy = y; b.vz = z; b.last = last;
        return b;
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rnd_elem();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0;
            default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
        endcase
    endfunction

    // loads both matrices fully, then builds
    task automatic queue_matrices(bit extremes);
        for (int i = 0; i < 16; i++) begin
            pending_beats.push_back(mk(MODE_LD_VIEW, 4'(i),
                extremes ? ((i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000) : rnd_elem(),
                $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1))));
            pending_beats.push_back(mk(MODE_LD_PROJ, 4'(i),
                extremes ? 32'h8000_0000 : rnd_elem(),
                $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1))));
        end
        pending_beats.push_back(mk(MODE_BUILD, 4'($urandom()), $urandom(), $urandom(),
                                   $urandom(), $urandom(), 1'($urandom_range(0, 1))));
    endtask

    task automatic queue_box(int corners);
        for (int i = 0; i < corners; i++)
            pending_beats.push_back(mk(MODE_VERTEX, 4'($urandom()), $urandom(),
                rnd_coord(), rnd_coord(), rnd_coord(), i == corners - 1));
    endtask

    // waits until every queued beat is sent and every expected result came back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || s_axis_tvalid || visible_q.size() != 0);
    endtask

    // driver
    int  send_gap;

    // decides whether a gap follows an accepted beat
    function automatic bit gap_pending();
        send_gap = gap_len();
        return send_gap > 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                void'(pending_beats.pop_front());
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (s_axis_tvalid && !s_axis_tready) begin
                // hold current beat
            end else if (pending_beats.size() > 0 && !hold_sender &&
                         !(s_axis_tvalid && s_axis_tready && gap_pending())) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, pending_beats[0].vz, pending_beats[0].vy,
                                  pending_beats[0].vx, pending_beats[0].value,
                                  pending_beats[0].idx};
                s_axis_tuser  <= pending_beats[0].op;
                s_axis_tlast  <= pending_beats[0].last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // predictor hook on the input side
    always @(posedge i_clk)
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_beat(mk(t_op'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[35:4],
                            s_axis_tdata[67:36], s_axis_tdata[99:68],
                            s_axis_tdata[131:100], s_axis_tlast));

    // monitor with random stalls
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (visible_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: visible=%0d", m_axis_tdata[0]);
                end else begin
                    if (m_axis_tdata[0] !== visible_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("visible mismatch: expected %0d, got %0d",
                                     visible_q[0], m_axis_tdata[0]);
                    end
                    void'(visible_q.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = gap_len();
                m_axis_tready <= (stall_left == 0) || ($urandom_range(0, 1) == 1);
            end
        end
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int total;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_LD_VIEW;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        hold_sender   = 1'b0;
        mismatches    = 0;
        hit_bits      = '0;
        for (int i = 0; i < 16; i++) begin view_m[i] = '0; proj_m[i] = '0; end
        for (int i = 0; i < 24; i++) planes[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: boxes before any build (all planes zero, always visible)
        queue_box(1);
        queue_box(3);
        // extreme matrices, saturating products
        queue_matrices(1'b1);
        pending_beats.push_back(mk(MODE_VERTEX, 4'hF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        pending_beats.push_back(mk(MODE_VERTEX, 4'd0, 32'd0, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        pending_beats.push_back(mk(MODE_VERTEX, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1));

        // pause until all results are in
        wait_drained();

        hold_sender = 1'b1;
        queue_matrices(1'b0);
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;

        total = 0;
        while (total < 1250) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 4) begin
                queue_matrices(1'b0);
                total += 33;
            end else if (r < 8) begin
                // build inside a box keeps the hit bits
                queue_box(0);
                pending_beats.push_back(mk(MODE_VERTEX, 4'd0, 32'd0, rnd_coord(),
                                           rnd_coord(), rnd_coord(), 1'b0));
                pending_beats.push_back(mk(MODE_BUILD, 4'd0, 32'd0, 32'd0, 32'd0,
                                           32'd0, 1'b0));
                queue_box(2);
                total += 4;
            end else begin
                int n;
                n = $urandom_range(1, 8);
                queue_box(n);
                total += n;
            end
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && visible_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
